// ===== rtl/core/tlsa_pkg.sv =====
// Shared definitions for the two-list slot allocator.
// Holds the request and status codes and the default pool size; no dependencies.
`timescale 1ns / 1ps

package tlsa_pkg;

  localparam int unsigned DEF_POOL_SLOTS = 16;

  localparam int unsigned STATUS_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ALLOC   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAIL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

endpackage

// ===== rtl/core/tlsa_link_mem.sv =====
// Next-link memory of the slot allocator: one write port, one registered read port.
// A read of the address written in the same cycle returns the new data; no dependencies.
`timescale 1ns / 1ps

module tlsa_link_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] rd_link
);

  logic [IDX_W-1:0] link_r [DEPTH];
  logic [IDX_W-1:0] rd_link_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_r[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_link_r <= wr_data;
    end else begin
      rd_link_r <= link_r[rd_addr];
    end
  end

  assign rd_link = rd_link_r;

endmodule

// ===== rtl/core/tlsa_list_core.sv =====
// List heads, clearing sweep and request decision of the slot allocator.
// Uses tlsa_pkg and instantiates tlsa_link_mem.
`timescale 1ns / 1ps

module tlsa_list_core
  import tlsa_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = DEF_POOL_SLOTS,
  parameter int unsigned IDX_W      = $clog2(POOL_SLOTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                exec,
  input  logic                req_op,
  input  logic [IDX_W-1:0]    req_slot,
  output logic                init_done,
  output logic [IDX_W-1:0]    res_slot,
  output logic [STATUS_W-1:0] res_status
);

  localparam logic [IDX_W-1:0] SENT   = IDX_W'(POOL_SLOTS - 1);
  localparam logic [IDX_W:0]   POOL_W = (IDX_W + 1)'(POOL_SLOTS);

  logic             init_done_r;
  logic [IDX_W-1:0] init_cnt_r;
  logic [IDX_W-1:0] clean_head_r;
  logic [IDX_W-1:0] clean_head_nxt;
  logic [IDX_W-1:0] recycled_head_r;
  logic [IDX_W-1:0] recycled_head_nxt;
  logic [IDX_W-1:0] recycled_next_r;
  logic [IDX_W-1:0] recycled_next_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_link;
  logic [IDX_W-1:0] clean_next;

  // The read port always tracks the link of the clean head that holds after this edge.
  tlsa_link_mem #(
    .DEPTH (POOL_SLOTS),
    .IDX_W (IDX_W)
  ) u_link_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_link (rd_link)
  );

  assign clean_next = ({1'b0, rd_link} >= POOL_W) ? SENT : rd_link;

  always_comb begin
    clean_head_nxt    = clean_head_r;
    recycled_head_nxt = recycled_head_r;
    recycled_next_nxt = recycled_next_r;
    wr_en             = !init_done_r;
    wr_addr           = init_cnt_r;
    wr_data           = init_cnt_r + IDX_W'(1);
    res_slot          = req_slot;
    res_status        = ST_IGNORED;
    if (req_op == OP_ALLOC) begin
      if (clean_head_r != SENT) begin
        res_slot       = clean_head_r;
        res_status     = ST_ALLOC;
        clean_head_nxt = clean_next;
      end else if (recycled_head_r != SENT) begin
        res_slot          = recycled_head_r;
        res_status        = ST_ALLOC;
        clean_head_nxt    = recycled_next_r;
        recycled_head_nxt = SENT;
      end else begin
        res_slot   = SENT;
        res_status = ST_FAIL;
      end
    end else if (req_slot < SENT) begin
      res_status        = ST_FREED;
      recycled_head_nxt = req_slot;
      recycled_next_nxt = recycled_head_r;
      if (exec) begin
        wr_en   = 1'b1;
        wr_addr = req_slot;
        wr_data = recycled_head_r;
      end
    end
  end

  assign rd_addr   = exec ? clean_head_nxt : clean_head_r;
  assign init_done = init_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_done_r     <= 1'b0;
      init_cnt_r      <= SENT;
      clean_head_r    <= '0;
      recycled_head_r <= SENT;
      recycled_next_r <= SENT;
    end else begin
      if (!init_done_r) begin
        if (init_cnt_r == '0) begin
          init_done_r <= 1'b1;
        end else begin
          init_cnt_r <= init_cnt_r - IDX_W'(1);
        end
      end
      if (exec) begin
        clean_head_r    <= clean_head_nxt;
        recycled_head_r <= recycled_head_nxt;
        recycled_next_r <= recycled_next_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/two_list_slot_allocator.sv =====
// Top level of the two-list slot allocator: input register, list core and result register.
// Uses tlsa_pkg and instantiates tlsa_list_core.
`timescale 1ns / 1ps

// The allocator hands out and takes back slots of a pool of POOL_SLOTS entries, the last of
// which is the sentinel returned when no slot is left. After reset the link memory is swept
// once, one entry per cycle, with in_tready held low. From then on one request item is
// taken per clock cycle while the output does not stall, each answered by exactly one
// result item; a request passes from the input register through the head update into the
// result register, and the one registered read port of the link memory is kept pointed at
// the next clean slot so that its link is ready when that slot is allocated. A stalled
// output holds the result and, once the input register is full, lowers in_tready.

module two_list_slot_allocator
  import tlsa_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = DEF_POOL_SLOTS
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_tvalid,
  output logic                                             in_tready,
  // Bits from the lowest up: slot_to_free, then zero fill.
  input  logic [((($clog2(POOL_SLOTS)) + 7) / 8) * 8 - 1:0] in_tdata,
  // Bit 0: op.
  input  logic [0:0]                                       in_tuser,
  output logic                                             out_tvalid,
  input  logic                                             out_tready,
  // Bits from the lowest up: slot_index, then zero fill.
  output logic [((($clog2(POOL_SLOTS)) + 7) / 8) * 8 - 1:0] out_tdata,
  // Bits from the lowest up: status.
  output logic [STATUS_W-1:0]                              out_tuser
);

  localparam int unsigned IDX_W  = $clog2(POOL_SLOTS);
  localparam int unsigned DATA_W = ((IDX_W + 7) / 8) * 8;

  logic                in_valid_r;
  logic                in_op_r;
  logic [IDX_W-1:0]    in_slot_r;
  logic                out_valid_r;
  logic [IDX_W-1:0]    out_slot_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                exec;
  logic                init_done;
  logic [IDX_W-1:0]    res_slot;
  logic [STATUS_W-1:0] res_status;

  tlsa_list_core #(
    .POOL_SLOTS (POOL_SLOTS),
    .IDX_W      (IDX_W)
  ) u_list_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .exec       (exec),
    .req_op     (in_op_r),
    .req_slot   (in_slot_r),
    .init_done  (init_done),
    .res_slot   (res_slot),
    .res_status (res_status)
  );

  assign exec      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = init_done && (!in_valid_r || exec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= in_tuser[0];
      in_slot_r <= in_tdata[IDX_W-1:0];
    end
    if (exec) begin
      out_slot_r   <= res_slot;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_slot_r);
  assign out_tuser  = out_status_r;

endmodule

// ===== rtl/core/tlsa_checker.sv =====
// Port-level checks for the two-list slot allocator, attached to the top level by bind.
// Uses tlsa_pkg.
`timescale 1ns / 1ps

module tlsa_checker
  import tlsa_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = DEF_POOL_SLOTS
) (
  input logic                                             clk,
  input logic                                             rst_n,
  input logic                                             in_tready,
  input logic                                             out_tvalid,
  input logic                                             out_tready,
  input logic [((($clog2(POOL_SLOTS)) + 7) / 8) * 8 - 1:0] out_tdata,
  input logic [STATUS_W-1:0]                              out_tuser
);

  localparam int unsigned      IDX_W = $clog2(POOL_SLOTS);
  localparam logic [IDX_W-1:0] SENT  = IDX_W'(POOL_SLOTS - 1);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled result item changed or vanished.");

  a_fail_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FAIL) |-> out_tdata[IDX_W-1:0] == SENT)
    else $error("Failed allocation did not return the sentinel.");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FREED || out_tuser == ST_IGNORED) |->
      ((out_tuser == ST_FREED) == (out_tdata[IDX_W-1:0] < SENT)))
    else $error("Free status does not match the echoed slot.");

  a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("Item accepted before the link memory sweep finished.");

endmodule

bind two_list_slot_allocator tlsa_checker #(
  .POOL_SLOTS (POOL_SLOTS)
) u_tlsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== bench/two_list_slot_allocator_tb.sv =====
// Self-checking testbench for the two-list slot allocator.
// It drives allocate and free requests, predicts every result and checks them in order.
// Depends on tlsa_pkg and two_list_slot_allocator.
`timescale 1ns / 1ps

module two_list_slot_allocator_tb;
  import tlsa_pkg::*;

  localparam int unsigned POOL_SLOTS = DEF_POOL_SLOTS;
  localparam int unsigned IDX_W = $clog2(POOL_SLOTS);
  localparam int unsigned DATA_W = ((IDX_W + 7) / 8) * 8;
  localparam logic [IDX_W-1:0] SENTINEL = IDX_W'(POOL_SLOTS - 1);

  typedef struct packed {
    logic [IDX_W-1:0]    slot_index;
    logic [STATUS_W-1:0] status;
  } slot_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = OP_ALLOC;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;

  logic [IDX_W-1:0] slot_link [POOL_SLOTS];
  logic [IDX_W-1:0] clean_top;
  logic [IDX_W-1:0] recycled_top;
  logic [IDX_W-1:0] held_slots [$];
  slot_result_t pending_results [$];
  int error_count = 0;
  bit steady_flow = 1'b0;

  two_list_slot_allocator #(
    .POOL_SLOTS(POOL_SLOTS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= steady_flow || ($urandom_range(99) >= 11);
  end

  function automatic void reset_lists();
    for (int i = 0; i < POOL_SLOTS; i++) begin
      slot_link[i] = IDX_W'(i + 1);
    end
    clean_top = '0;
    recycled_top = SENTINEL;
  endfunction

  function automatic slot_result_t apply_request(logic op, logic [IDX_W-1:0] slot);
    slot_result_t res;
    logic [IDX_W-1:0] swap_tmp;
    if (op == OP_ALLOC) begin
      if (clean_top == SENTINEL) begin
        swap_tmp = clean_top;
        clean_top = recycled_top;
        recycled_top = swap_tmp;
      end
      if (clean_top == SENTINEL) begin
        res.slot_index = SENTINEL;
        res.status = ST_FAIL;
      end else begin
        res.slot_index = clean_top;
        clean_top = slot_link[clean_top];
        res.status = ST_ALLOC;
      end
    end else begin
      res.slot_index = slot;
      if (slot >= SENTINEL) begin
        res.status = ST_IGNORED;
      end else begin
        slot_link[slot] = recycled_top;
        recycled_top = slot;
        res.status = ST_FREED;
      end
    end
    return res;
  endfunction

  task automatic send_request(logic op, logic [IDX_W-1:0] slot);
    slot_result_t res;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= DATA_W'(slot);
    do @(posedge clk); while (!in_tready);
    res = apply_request(op, slot);
    pending_results.push_back(res);
    if (res.status == ST_ALLOC) begin
      held_slots.push_back(res.slot_index);
    end
    if (!steady_flow && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic free_held_slot();
    int pick;
    pick = $urandom_range(held_slots.size() - 1);
    send_request(OP_FREE, held_slots[pick]);
    held_slots.delete(pick);
  endtask

  always @(posedge clk) begin : check_results
    slot_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: slot_index %0d status %0d", out_tdata[IDX_W-1:0],
          out_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[IDX_W-1:0] !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, out_tdata[IDX_W-1:0]);
          error_count++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          error_count++;
        end
        if (out_tdata[DATA_W-1:IDX_W] !== '0) begin
          $error("tdata fill: expected 0, got %0h", out_tdata[DATA_W-1:IDX_W]);
          error_count++;
        end
      end
    end
  end

  task automatic test_drain_after_reset();
    for (int i = 0; i < POOL_SLOTS + 1; i++) begin
      send_request(OP_ALLOC, IDX_W'($urandom));
    end
    send_request(OP_FREE, SENTINEL);
  endtask

  task automatic test_recycle_swap();
    send_request(OP_FREE, '0);
    send_request(OP_FREE, SENTINEL - 1'b1);
    send_request(OP_FREE, IDX_W'(7));
    for (int i = 0; i < 4; i++) begin
      send_request(OP_ALLOC, '1);
    end
  endtask

  task automatic test_random_traffic(int num_items);
    int alloc_pct;
    alloc_pct = 50;
    for (int i = 0; i < num_items; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0: alloc_pct = 20;
          1: alloc_pct = 50;
          default: alloc_pct = 80;
        endcase
      end
      steady_flow = (i >= num_items / 3) && (i < num_items / 2);
      if ($urandom_range(99) < 4) begin
        send_request(OP_FREE, SENTINEL);
      end else if ($urandom_range(99) < alloc_pct || held_slots.size() == 0) begin
        send_request(OP_ALLOC, IDX_W'($urandom));
      end else begin
        free_held_slot();
      end
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_double_free(int num_items);
    for (int i = 0; i < num_items; i++) begin
      if ($urandom_range(1)) begin
        send_request(OP_FREE, IDX_W'($urandom));
      end else begin
        send_request(OP_ALLOC, IDX_W'($urandom));
      end
    end
  endtask

  initial begin
    reset_lists();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_drain_after_reset();
    test_recycle_swap();
    test_random_traffic(1500);
    test_double_free(200);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
